// ===== rtl/core/fppt_pkg.sv =====
package fppt_pkg;

    localparam int FLOW_W  = 20;
    localparam int TIME_W  = 22;
    localparam int PHASE_W = TIME_W + 1;
    localparam int CYC_W   = 5;
    localparam int MINF_W  = 15;
    localparam int DIVD_W  = TIME_W + FLOW_W;
    localparam int PCT_W   = 27;

    localparam logic [0:0] REG_MAX_FLOW = 1'b0;
    localparam logic [0:0] REG_FLOW     = 1'b1;

    localparam logic [CYC_W-1:0] CYC_ONE    = 5'd1;
    localparam logic [CYC_W-1:0] CYC_FOUR   = 5'd4;
    localparam logic [CYC_W-1:0] CYC_FIFTEEN = 5'd15;
    localparam logic [CYC_W-1:0] CYC_THIRTY = 5'd30;

    localparam logic [PCT_W-1:0] PCT_FULL   = 27'd100;
    localparam logic [PCT_W-1:0] BAND_LOW   = 27'd5;
    localparam logic [PCT_W-1:0] BAND_MID   = 27'd10;
    localparam logic [PCT_W-1:0] BAND_HIGH  = 27'd25;
    localparam logic [PCT_W-1:0] BAND_TOP   = 27'd75;

    localparam logic [FLOW_W-1:0] MINUTES_PER_HOUR = 20'd60;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [FLOW_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic [TIME_W-1:0] on_ms;
        logic [TIME_W-1:0] off_ms;
        logic [TIME_W-1:0] period_ms;
        logic [CYC_W-1:0]  cycles;
        logic [MINF_W-1:0] min_flow;
    } t_limits;

endpackage

// ===== rtl/core/flow_proportioned_pump_timer_unit.sv =====
// Channel   Direction  Handshake                    Payload
// tick      in         i_tick_valid / o_tick_ready  i_tick
// result    out        o_res_valid / i_res_ready    o_pump_on, o_phase_ms, o_on_time_ms,
//                                                   o_off_time_ms, o_cycles_per_hour, o_min_flow
// config    in         i_cfg_we                     i_cfg_idx, i_cfg_wdata
//
// When a tick beat is taken, its result beat is valid from the next cycle.
// A register write restarts the recompute sequence: the PREP and BAND setup states and four
// passes of the shared restoring divider (three when max_flow is zero, which skips the run
// pass), with tick input held off during the write cycle and the whole sequence.
// After reset the sequence runs once, with max_flow zero, before the first tick beat is taken.
// A waiting result does not block the next tick beat when the result is taken in that cycle.
module flow_proportioned_pump_timer_unit #(
    parameter int WINDOW_MS = 3600000
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_tick_valid,
    output logic                        o_tick_ready,
    input  logic                        i_tick,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic                        o_pump_on,
    output logic [fppt_pkg::TIME_W-1:0] o_phase_ms,
    output logic [fppt_pkg::TIME_W-1:0] o_on_time_ms,
    output logic [fppt_pkg::TIME_W-1:0] o_off_time_ms,
    output logic [fppt_pkg::CYC_W-1:0]  o_cycles_per_hour,
    output logic [fppt_pkg::MINF_W-1:0] o_min_flow,
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_idx,
    input  logic [fppt_pkg::FLOW_W-1:0] i_cfg_wdata
);

    logic [fppt_pkg::FLOW_W-1:0]  r_max_flow;
    logic [fppt_pkg::FLOW_W-1:0]  r_flow;
    logic [fppt_pkg::PHASE_W-1:0] r_phase;
    logic                         r_pump;
    logic                         r_res_valid;
    logic                         r_out_pump;
    logic [fppt_pkg::TIME_W-1:0]  r_out_phase;
    logic [fppt_pkg::TIME_W-1:0]  r_out_on;
    logic [fppt_pkg::TIME_W-1:0]  r_out_off;
    logic [fppt_pkg::CYC_W-1:0]   r_out_cyc;
    logic [fppt_pkg::MINF_W-1:0]  r_out_min;

    logic                         n_pump;
    logic [fppt_pkg::PHASE_W-1:0] n_phase;
    logic                         w_busy;
    logic                         w_take;
    fppt_pkg::t_limits            w_lim;

    fppt_seq #(
        .WINDOW_MS (WINDOW_MS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cfg_we),
        .i_max_flow (r_max_flow),
        .i_flow     (r_flow),
        .o_busy     (w_busy),
        .o_lim      (w_lim)
    );

    assign o_tick_ready = !w_busy && !i_cfg_we && (!r_res_valid || i_res_ready);
    assign w_take       = i_tick_valid && o_tick_ready;

    always_comb begin
        n_pump  = r_pump;
        n_phase = r_phase;
        if (i_tick) begin
            if (r_phase <= fppt_pkg::PHASE_W'(w_lim.on_ms)) begin
                n_pump  = 1'b1;
                n_phase = r_phase + 1'b1;
            end else if (r_phase <= fppt_pkg::PHASE_W'(w_lim.period_ms)) begin
                n_pump  = 1'b0;
                n_phase = r_phase + 1'b1;
            end else begin
                n_phase = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_flow  <= '0;
            r_flow      <= '0;
            r_phase     <= '0;
            r_pump      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fppt_pkg::REG_MAX_FLOW: r_max_flow <= i_cfg_wdata;
                    fppt_pkg::REG_FLOW:     r_flow     <= i_cfg_wdata;
                    default:                r_flow     <= r_flow;
                endcase
                r_phase <= '0;
            end else if (w_take) begin
                r_phase <= n_phase;
                r_pump  <= n_pump;
            end
            if (w_take) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_pump  <= n_pump;
            r_out_phase <= r_phase[fppt_pkg::TIME_W-1:0];
            r_out_on    <= w_lim.on_ms;
            r_out_off   <= w_lim.off_ms;
            r_out_cyc   <= w_lim.cycles;
            r_out_min   <= w_lim.min_flow;
        end
    end

    assign o_res_valid       = r_res_valid;
    assign o_pump_on         = r_out_pump;
    assign o_phase_ms        = r_out_phase;
    assign o_on_time_ms      = r_out_on;
    assign o_off_time_ms     = r_out_off;
    assign o_cycles_per_hour = r_out_cyc;
    assign o_min_flow        = r_out_min;

`ifndef ASSERT_OFF
    a_no_tick_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !o_tick_ready)
        else $error("tick beat offered while limits are recomputed");

    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (w_busy && r_phase == '0))
        else $error("register write did not restart the recompute and phase");

    a_phase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= fppt_pkg::PHASE_W'(w_lim.period_ms) + fppt_pkg::PHASE_W'(1))
        else $error("phase count ran past the period limit");
`endif

endmodule

// ===== rtl/core/fppt_div.sv =====
module fppt_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fppt_pkg::t_div_req i_req,
    output fppt_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(fppt_pkg::DIVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(fppt_pkg::DIVD_W - 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [fppt_pkg::DIVD_W-1:0] r_quo;
    logic [fppt_pkg::FLOW_W-1:0] r_rem;
    logic [fppt_pkg::FLOW_W-1:0] r_dvs;

    logic [fppt_pkg::FLOW_W:0]   w_rem_sh;
    logic [fppt_pkg::FLOW_W:0]   w_rem_sub;
    logic                        w_fit;

    assign w_rem_sh  = {r_rem, r_quo[fppt_pkg::DIVD_W-1]};
    assign w_fit     = (w_rem_sh >= {1'b0, r_dvs});
    assign w_rem_sub = w_rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[fppt_pkg::DIVD_W-2:0], w_fit};
            r_rem <= w_fit ? w_rem_sub[fppt_pkg::FLOW_W-1:0] : w_rem_sh[fppt_pkg::FLOW_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== rtl/core/fppt_seq.sv =====
module fppt_seq #(
    parameter int WINDOW_MS = 3600000
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [fppt_pkg::FLOW_W-1:0] i_max_flow,
    input  logic [fppt_pkg::FLOW_W-1:0] i_flow,
    output logic                        o_busy,
    output fppt_pkg::t_limits           o_lim
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PREP   = 4'd1;
    localparam logic [3:0] S_BAND   = 4'd2;
    localparam logic [3:0] S_RUN_GO = 4'd3;
    localparam logic [3:0] S_RUN_WT = 4'd4;
    localparam logic [3:0] S_ON_GO  = 4'd5;
    localparam logic [3:0] S_ON_WT  = 4'd6;
    localparam logic [3:0] S_OFF_GO = 4'd7;
    localparam logic [3:0] S_OFF_WT = 4'd8;
    localparam logic [3:0] S_MIN_GO = 4'd9;
    localparam logic [3:0] S_MIN_WT = 4'd10;

    localparam logic [fppt_pkg::TIME_W-1:0] WINDOW = fppt_pkg::TIME_W'(WINDOW_MS);

    logic [3:0]                  r_state;
    logic [fppt_pkg::FLOW_W-1:0] r_fc;
    logic [fppt_pkg::DIVD_W-1:0] r_prod;
    logic [fppt_pkg::TIME_W-1:0] r_run;
    logic [fppt_pkg::TIME_W-1:0] r_on;
    logic [fppt_pkg::TIME_W-1:0] r_off;
    logic [fppt_pkg::TIME_W-1:0] r_period;
    logic [fppt_pkg::CYC_W-1:0]  r_n;
    logic [fppt_pkg::MINF_W-1:0] r_min;

    fppt_pkg::t_div_req          w_req;
    fppt_pkg::t_div_rsp          w_rsp;
    logic [fppt_pkg::PCT_W-1:0]  w_pct;
    logic [fppt_pkg::PCT_W-1:0]  w_mf;
    logic [fppt_pkg::CYC_W-1:0]  w_band;
    logic [fppt_pkg::TIME_W-1:0] w_q;
    logic [fppt_pkg::MINF_W-1:0] w_qmin;

    fppt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_pct  = fppt_pkg::PCT_W'(r_fc) * fppt_pkg::PCT_FULL;
    assign w_mf   = fppt_pkg::PCT_W'(i_max_flow);
    assign w_q    = w_rsp.quotient[fppt_pkg::TIME_W-1:0];
    assign w_qmin = w_rsp.quotient[fppt_pkg::MINF_W-1:0];

    always_comb begin
        if (r_fc == '0) begin
            w_band = fppt_pkg::CYC_ONE;
        end else if (w_pct <= w_mf * fppt_pkg::BAND_LOW) begin
            w_band = fppt_pkg::CYC_ONE;
        end else if (w_pct <= w_mf * fppt_pkg::BAND_MID) begin
            w_band = fppt_pkg::CYC_FOUR;
        end else if (w_pct <= w_mf * fppt_pkg::BAND_HIGH) begin
            w_band = fppt_pkg::CYC_FIFTEEN;
        end else if (w_pct <= w_mf * fppt_pkg::BAND_TOP) begin
            w_band = fppt_pkg::CYC_THIRTY;
        end else begin
            w_band = fppt_pkg::CYC_ONE;
        end
    end

    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = '0;
        w_req.divisor  = '0;
        case (r_state)
            S_RUN_GO: begin
                w_req.start    = 1'b1;
                w_req.dividend = r_prod;
                w_req.divisor  = i_max_flow;
            end
            S_ON_GO: begin
                w_req.start    = 1'b1;
                w_req.dividend = fppt_pkg::DIVD_W'(r_run);
                w_req.divisor  = fppt_pkg::FLOW_W'(r_n);
            end
            S_OFF_GO: begin
                w_req.start    = 1'b1;
                w_req.dividend = fppt_pkg::DIVD_W'(WINDOW - r_run);
                w_req.divisor  = fppt_pkg::FLOW_W'(r_n);
            end
            S_MIN_GO: begin
                w_req.start    = 1'b1;
                w_req.dividend = fppt_pkg::DIVD_W'(i_max_flow);
                w_req.divisor  = fppt_pkg::MINUTES_PER_HOUR;
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_PREP;
            r_on     <= '0;
            r_off    <= WINDOW;
            r_period <= WINDOW;
            r_n      <= fppt_pkg::CYC_ONE;
            r_min    <= '0;
        end else if (i_start) begin
            r_state <= S_PREP;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_state <= S_IDLE;
                end
                S_PREP: begin
                    r_state <= S_BAND;
                end
                S_BAND: begin
                    r_n     <= w_band;
                    r_state <= (i_max_flow == '0) ? S_ON_GO : S_RUN_GO;
                end
                S_RUN_GO: begin
                    r_state <= S_RUN_WT;
                end
                S_RUN_WT: begin
                    if (w_rsp.done) begin
                        r_state <= S_ON_GO;
                    end
                end
                S_ON_GO: begin
                    r_state <= S_ON_WT;
                end
                S_ON_WT: begin
                    if (w_rsp.done) begin
                        r_on    <= w_q;
                        r_state <= S_OFF_GO;
                    end
                end
                S_OFF_GO: begin
                    r_state <= S_OFF_WT;
                end
                S_OFF_WT: begin
                    if (w_rsp.done) begin
                        r_off    <= w_q;
                        r_period <= r_on + w_q;
                        r_state  <= S_MIN_GO;
                    end
                end
                S_MIN_GO: begin
                    r_state <= S_MIN_WT;
                end
                S_MIN_WT: begin
                    if (w_rsp.done) begin
                        r_min   <= (w_qmin == '0) ? '0 : w_qmin + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_PREP;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PREP) begin
            r_fc <= (i_flow > i_max_flow) ? i_max_flow : i_flow;
        end
        if (r_state == S_BAND) begin
            r_prod <= fppt_pkg::DIVD_W'(WINDOW) * fppt_pkg::DIVD_W'(r_fc);
            r_run  <= '0;
        end
        if (r_state == S_RUN_WT && w_rsp.done) begin
            r_run <= w_q;
        end
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_lim.on_ms     = r_on;
    assign o_lim.off_ms    = r_off;
    assign o_lim.period_ms = r_period;
    assign o_lim.cycles    = r_n;
    assign o_lim.min_flow  = r_min;

endmodule

// ===== bench/tb_flow_proportioned_pump_timer_unit.sv =====
`timescale 1ns / 100ps

module tb_flow_proportioned_pump_timer_unit;

    localparam longint unsigned HOUR_MS = 64'd3600000;

    typedef struct packed {
        logic                        pump_on;
        logic [fppt_pkg::TIME_W-1:0] phase_ms;
        logic [fppt_pkg::TIME_W-1:0] on_ms;
        logic [fppt_pkg::TIME_W-1:0] off_ms;
        logic [fppt_pkg::CYC_W-1:0]  cycles;
        logic [fppt_pkg::MINF_W-1:0] min_flow;
    } t_pump_beat;

    typedef enum logic {
        ROW_TICK,
        ROW_WRITE
    } t_row_kind;

    typedef struct {
        t_row_kind                   kind;
        logic [0:0]                  idx;
        logic [fppt_pkg::FLOW_W-1:0] data;
        logic                        tick;
        bit                          pinned;
        t_pump_beat                  want;
    } t_plan_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_tick_valid = 1'b0;
    logic                          o_tick_ready;
    logic                          i_tick = 1'b0;
    logic                          o_res_valid;
    logic                          i_res_ready = 1'b0;
    logic                          o_pump_on;
    logic [fppt_pkg::TIME_W-1:0]   o_phase_ms;
    logic [fppt_pkg::TIME_W-1:0]   o_on_time_ms;
    logic [fppt_pkg::TIME_W-1:0]   o_off_time_ms;
    logic [fppt_pkg::CYC_W-1:0]    o_cycles_per_hour;
    logic [fppt_pkg::MINF_W-1:0]   o_min_flow;
    logic                          i_cfg_we = 1'b0;
    logic [0:0]                    i_cfg_idx = 1'b0;
    logic [fppt_pkg::FLOW_W-1:0]   i_cfg_wdata = '0;

    logic [fppt_pkg::FLOW_W-1:0]  cfg_max_flow;
    logic [fppt_pkg::FLOW_W-1:0]  cfg_flow;
    logic [fppt_pkg::PHASE_W-1:0] phase_cnt;
    logic [fppt_pkg::TIME_W-1:0]  on_lim;
    logic [fppt_pkg::TIME_W-1:0]  off_len;
    logic [fppt_pkg::TIME_W-1:0]  period_lim;
    logic                         pump_lvl;
    logic [fppt_pkg::CYC_W-1:0]   n_cyc;
    logic [fppt_pkg::MINF_W-1:0]  min_flow_lim;

    t_pump_beat beat_q[$];
    t_plan_row  plan[$];
    bit         pin_on;
    t_pump_beat pin_beat;
    int         fail_cnt;
    int         gap_pct;
    int         stall_pct;
    int         hold_len;

    flow_proportioned_pump_timer_unit DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_tick_valid      (i_tick_valid),
        .o_tick_ready      (o_tick_ready),
        .i_tick            (i_tick),
        .o_res_valid       (o_res_valid),
        .i_res_ready       (i_res_ready),
        .o_pump_on         (o_pump_on),
        .o_phase_ms        (o_phase_ms),
        .o_on_time_ms      (o_on_time_ms),
        .o_off_time_ms     (o_off_time_ms),
        .o_cycles_per_hour (o_cycles_per_hour),
        .o_min_flow        (o_min_flow),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic void recalc_durations();
        longint unsigned mf;
        longint unsigned f;
        longint unsigned pct;
        longint unsigned run_ms;
        logic [fppt_pkg::CYC_W-1:0] n;
        mf = cfg_max_flow;
        f = cfg_flow;
        if (f > mf) f = mf;
        n = fppt_pkg::CYC_ONE;
        run_ms = 0;
        if (mf != 0) begin
            pct = 100 * f;
            if (f == 0 || pct <= 5 * mf) n = fppt_pkg::CYC_ONE;
            else if (pct <= 10 * mf) n = fppt_pkg::CYC_FOUR;
            else if (pct <= 25 * mf) n = fppt_pkg::CYC_FIFTEEN;
            else if (pct <= 75 * mf) n = fppt_pkg::CYC_THIRTY;
            else n = fppt_pkg::CYC_ONE;
            run_ms = (HOUR_MS * f) / mf;
        end
        n_cyc = n;
        on_lim = fppt_pkg::TIME_W'(run_ms / n);
        off_len = fppt_pkg::TIME_W'((HOUR_MS - run_ms) / n);
        period_lim = on_lim + off_len;
        min_flow_lim = fppt_pkg::MINF_W'(cfg_max_flow / 60);
        if (min_flow_lim != 0) min_flow_lim = min_flow_lim + 1'b1;
        phase_cnt = '0;
    endfunction

    function automatic void reset_timer();
        cfg_max_flow = '0;
        cfg_flow = '0;
        pump_lvl = 1'b0;
        recalc_durations();
    endfunction

    function automatic void write_timer_reg(logic [0:0] idx,
                                            logic [fppt_pkg::FLOW_W-1:0] value);
        if (idx == fppt_pkg::REG_MAX_FLOW) cfg_max_flow = value;
        else cfg_flow = value;
        recalc_durations();
    endfunction

    function automatic t_pump_beat advance_phase(logic tick);
        t_pump_beat r;
        r.phase_ms = phase_cnt[fppt_pkg::TIME_W-1:0];
        if (tick) begin
            if (phase_cnt <= on_lim) begin
                pump_lvl = 1'b1;
                phase_cnt = phase_cnt + 1'b1;
            end else if (phase_cnt <= period_lim) begin
                pump_lvl = 1'b0;
                phase_cnt = phase_cnt + 1'b1;
            end else begin
                phase_cnt = '0;
            end
        end
        r.pump_on = pump_lvl;
        r.on_ms = on_lim;
        r.off_ms = off_len;
        r.cycles = n_cyc;
        r.min_flow = min_flow_lim;
        return r;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            fail_cnt++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_pump_beat seen;
        t_pump_beat due;
        t_pump_beat calc;
        if (i_rst_n) begin
            if (o_res_valid && i_res_ready) begin
                seen = '{o_pump_on, o_phase_ms, o_on_time_ms, o_off_time_ms,
                         o_cycles_per_hour, o_min_flow};
                if (beat_q.size() == 0) begin
                    fail_cnt++;
                    $error("result beat with no tick waiting for it");
                end else begin
                    due = beat_q.pop_front();
                    check_field("pump_on", due.pump_on, seen.pump_on);
                    check_field("phase_ms", due.phase_ms, seen.phase_ms);
                    check_field("on_time_ms", due.on_ms, seen.on_ms);
                    check_field("off_time_ms", due.off_ms, seen.off_ms);
                    check_field("cycles_per_hour", due.cycles, seen.cycles);
                    check_field("min_flow", due.min_flow, seen.min_flow);
                end
            end
            if (i_tick_valid && o_tick_ready) begin
                calc = advance_phase(i_tick);
                beat_q.push_back(pin_on ? pin_beat : calc);
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_len > 0) begin
            i_res_ready <= 1'b0;
            hold_len = hold_len - 1;
        end else begin
            i_res_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_tick(logic val, bit pinned, t_pump_beat want);
        while ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            i_tick_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_tick_valid <= 1'b1;
        i_tick <= val;
        pin_on = pinned;
        pin_beat = want;
        do @(posedge i_clk); while (!o_tick_ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_tick_valid <= 1'b0;
        while (beat_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [fppt_pkg::FLOW_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        write_timer_reg(idx, value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_random_flow();
        int mode;
        logic [fppt_pkg::FLOW_W-1:0] mf;
        logic [fppt_pkg::FLOW_W-1:0] fl;
        mode = $urandom_range(5);
        mf = fppt_pkg::FLOW_W'($urandom_range(20'hFFFFF));
        fl = fppt_pkg::FLOW_W'($urandom_range(20'hFFFFF));
        case (mode)
            1: begin
                mf = '1;
                fl = fppt_pkg::FLOW_W'($urandom_range(8));
            end
            2: begin
                mf = fppt_pkg::FLOW_W'($urandom_range(1000, 1));
                fl = fppt_pkg::FLOW_W'($urandom_range(mf));
            end
            3: begin
                mf = fppt_pkg::FLOW_W'($urandom_range(20'hFFFFF, 1));
                fl = fppt_pkg::FLOW_W'((64'(mf) * $urandom_range(100)) / 100
                                       + $urandom_range(1));
            end
            5: mf = '0;
            default: ;
        endcase
        if (mode == 4) begin
            write_reg($urandom_range(1) ? fppt_pkg::REG_FLOW : fppt_pkg::REG_MAX_FLOW, fl);
        end else begin
            write_reg(fppt_pkg::REG_MAX_FLOW, mf);
            write_reg(fppt_pkg::REG_FLOW, fl);
        end
    endtask

    task automatic run_blocks(int blocks, int per_block, int gap, int stall);
        gap_pct = gap;
        stall_pct = stall;
        repeat (blocks) begin
            drain();
            set_random_flow();
            repeat (per_block) send_tick($urandom_range(99) < 85, 1'b0, '0);
        end
    endtask

    function automatic void plan_write(logic [0:0] idx, logic [fppt_pkg::FLOW_W-1:0] data);
        plan.push_back('{ROW_WRITE, idx, data, 1'b0, 1'b0, '0});
    endfunction

    function automatic void plan_tick(logic val);
        plan.push_back('{ROW_TICK, fppt_pkg::REG_MAX_FLOW, '0, val, 1'b0, '0});
    endfunction

    function automatic void plan_pinned(logic val, t_pump_beat want);
        plan.push_back('{ROW_TICK, fppt_pkg::REG_MAX_FLOW, '0, val, 1'b1, want});
    endfunction

    initial begin
        #20_000_000;
        $display("tb_flow_proportioned_pump_timer_unit NOT OK");
        $finish;
    end

    initial begin
        fail_cnt = 0;
        gap_pct = 0;
        stall_pct = 0;
        hold_len = 0;
        pin_on = 1'b0;
        pin_beat = '0;
        reset_timer();

        plan_pinned(1'b1, '{1'b1, 22'd0, 22'd0, 22'd3600000, 5'd1, 15'd0});
        plan_pinned(1'b1, '{1'b0, 22'd1, 22'd0, 22'd3600000, 5'd1, 15'd0});
        plan_pinned(1'b0, '{1'b0, 22'd2, 22'd0, 22'd3600000, 5'd1, 15'd0});
        plan_write(fppt_pkg::REG_MAX_FLOW, 20'hFFFFF);
        plan_pinned(1'b1, '{1'b1, 22'd0, 22'd0, 22'd3600000, 5'd1, 15'd17477});
        plan_write(fppt_pkg::REG_FLOW, 20'hFFFFF);
        plan_pinned(1'b1, '{1'b1, 22'd0, 22'd3600000, 22'd0, 5'd1, 15'd17477});
        plan_write(fppt_pkg::REG_MAX_FLOW, 20'd0);
        plan_pinned(1'b1, '{1'b1, 22'd0, 22'd0, 22'd3600000, 5'd1, 15'd0});
        plan_write(fppt_pkg::REG_MAX_FLOW, 20'd100);
        plan_write(fppt_pkg::REG_FLOW, 20'd5);
        plan_tick(1'b1);
        plan_write(fppt_pkg::REG_FLOW, 20'd6);
        plan_tick(1'b1);
        plan_write(fppt_pkg::REG_FLOW, 20'd25);
        plan_tick(1'b1);
        plan_write(fppt_pkg::REG_FLOW, 20'd26);
        plan_tick(1'b1);
        plan_write(fppt_pkg::REG_FLOW, 20'd76);
        plan_tick(1'b1);
        plan_write(fppt_pkg::REG_MAX_FLOW, 20'd60);
        plan_tick(1'b1);
        plan_write(fppt_pkg::REG_MAX_FLOW, 20'hFFFFF);
        plan_write(fppt_pkg::REG_FLOW, 20'd1);
        repeat (6) plan_tick(1'b1);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                drain();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                send_tick(plan[i].tick, plan[i].pinned, plan[i].want);
            end
        end

        run_blocks(6, 25, 0, 0);
        run_blocks(6, 25, 55, 0);
        run_blocks(6, 25, 0, 55);
        run_blocks(6, 25, 35, 35);

        // The receiver holds off long enough for the block to back up into the tick input.
        drain();
        gap_pct = 0;
        stall_pct = 0;
        set_random_flow();
        @(posedge i_clk);
        hold_len = 400;
        repeat (50) send_tick($urandom_range(99) < 85, 1'b0, '0);

        run_blocks(1, 25, 0, 0);

        // Half flow runs the phase count with ticks back to back.
        drain();
        gap_pct = 0;
        stall_pct = 0;
        write_reg(fppt_pkg::REG_MAX_FLOW, 20'd100);
        write_reg(fppt_pkg::REG_FLOW, 20'd50);
        repeat (30) send_tick(1'b1, 1'b0, '0);

        drain();
        repeat (20) @(posedge i_clk);
        if (beat_q.size() != 0) begin
            fail_cnt++;
            $error("%0d expected result beats never arrived", beat_q.size());
        end
        if (fail_cnt == 0) $display("tb_flow_proportioned_pump_timer_unit OK");
        else $display("tb_flow_proportioned_pump_timer_unit NOT OK");
        $finish;
    end

endmodule
